/* rtl/qpm_pkg.sv */
package qpm_pkg;

    localparam int COMPONENT_WIDTH = 16;

    localparam int CW      = COMPONENT_WIDTH;
    localparam int FRAC_W  = CW - 1;
    localparam int OPD_W   = CW + 1;
    localparam int PROD_W  = 2 * OPD_W;
    localparam int SUM_W   = PROD_W + 2;
    localparam int SHIFT_W = SUM_W - FRAC_W;

    typedef logic signed [CW-1:0]      comp_t;
    typedef logic signed [OPD_W-1:0]   opd_t;
    typedef logic signed [PROD_W-1:0]  prod_t;
    typedef logic signed [SUM_W-1:0]   sum_t;
    typedef logic signed [SHIFT_W-1:0] shift_t;

    typedef enum logic [1:0] {
        FUNC_AB     = 2'd0,
        FUNC_CONJ_A = 2'd1,
        FUNC_CONJ_B = 2'd2,
        FUNC_UNUSED = 2'd3
    } func_t;

    localparam sum_t   ROUND_HALF = sum_t'(1) <<< (FRAC_W - 1);
    localparam shift_t COMP_MAX   = (shift_t'(1) <<< (CW - 1)) - shift_t'(1);
    localparam shift_t COMP_MIN   = -COMP_MAX - shift_t'(1);

    typedef struct packed {
        comp_t value;
        logic  clipped;
    } rsat_t;

endpackage

/* rtl/qpm_round_sat.sv */
module qpm_round_sat (
    input  qpm_pkg::sum_t  sum,
    output qpm_pkg::rsat_t res
);
    import qpm_pkg::*;

    sum_t   rounded;
    shift_t shifted;

    always_comb
    begin
        rounded = sum + ROUND_HALF;
        shifted = rounded[SUM_W-1:FRAC_W];
        if (shifted > COMP_MAX)
        begin
            res.value   = comp_t'(COMP_MAX);
            res.clipped = 1'b1;
        end
        else if (shifted < COMP_MIN)
        begin
            res.value   = comp_t'(COMP_MIN);
            res.clipped = 1'b1;
        end
        else
        begin
            res.value   = shifted[CW-1:0];
            res.clipped = 1'b0;
        end
    end

endmodule

/* rtl/quaternion_product_modes_core.sv */
// Quaternion Hamilton product in signed fixed point with one sign bit and
// COMPONENT_WIDTH-1 fractional bits: func selects a*b, conj(a)*b or a*conj(b),
// and the unused code behaves as a*b. Each output component is the exact sum
// of four products, rounded half up and saturated; saturated is high when any
// component was clipped. The block is a four-stage pipeline (conjugate, the
// sixteen multiplies, the four sums, rounding and saturation), and a new
// request can be accepted on every cycle while in_stall is low. Each stage
// holds its request only while the stage after it is full and stalled, so
// in_stall rises only once all four stages are full behind a stalled output.
module quaternion_product_modes_core (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic [1:0]    func,
    input  qpm_pkg::comp_t a_w,
    input  qpm_pkg::comp_t a_x,
    input  qpm_pkg::comp_t a_y,
    input  qpm_pkg::comp_t a_z,
    input  qpm_pkg::comp_t b_w,
    input  qpm_pkg::comp_t b_x,
    input  qpm_pkg::comp_t b_y,
    input  qpm_pkg::comp_t b_z,
    output logic          out_valid,
    input  logic          out_stall,
    output qpm_pkg::comp_t r_w,
    output qpm_pkg::comp_t r_x,
    output qpm_pkg::comp_t r_y,
    output qpm_pkg::comp_t r_z,
    output logic          saturated
);
    import qpm_pkg::*;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    logic en1, en2, en3, en4;

    opd_t  qa_next [4];
    opd_t  qb_next [4];
    opd_t  qa_reg  [4];
    opd_t  qb_reg  [4];
    prod_t prod_next [4][4];
    prod_t prod_reg  [4][4];
    sum_t  sum_next [4];
    sum_t  sum_reg  [4];
    rsat_t rs [4];
    comp_t res_reg [4];
    logic  sat_reg;

    assign en4      = !v4_reg || !out_stall;
    assign en3      = !v3_reg || en4;
    assign en2      = !v2_reg || en3;
    assign en1      = !v1_reg || en2;
    assign in_stall = !en1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else
        begin
            if (en1)
            begin
                v1_reg <= in_valid;
            end
            if (en2)
            begin
                v2_reg <= v1_reg;
            end
            if (en3)
            begin
                v3_reg <= v2_reg;
            end
            if (en4)
            begin
                v4_reg <= v3_reg;
            end
        end
    end

    // The conjugate is taken one bit wider so that the most negative value
    // does not wrap.
    always_comb
    begin
        qa_next[0] = OPD_W'(a_w);
        qa_next[1] = OPD_W'(a_x);
        qa_next[2] = OPD_W'(a_y);
        qa_next[3] = OPD_W'(a_z);
        qb_next[0] = OPD_W'(b_w);
        qb_next[1] = OPD_W'(b_x);
        qb_next[2] = OPD_W'(b_y);
        qb_next[3] = OPD_W'(b_z);
        unique case (func_t'(func))
            FUNC_CONJ_A:
            begin
                qa_next[1] = -OPD_W'(a_x);
                qa_next[2] = -OPD_W'(a_y);
                qa_next[3] = -OPD_W'(a_z);
            end
            FUNC_CONJ_B:
            begin
                qb_next[1] = -OPD_W'(b_x);
                qb_next[2] = -OPD_W'(b_y);
                qb_next[3] = -OPD_W'(b_z);
            end
            default:
            begin
            end
        endcase
    end

    always_comb
    begin
        prod_next[0][0] = PROD_W'(qa_reg[0]) * PROD_W'(qb_reg[0]);
        prod_next[0][1] = PROD_W'(qa_reg[1]) * PROD_W'(qb_reg[1]);
        prod_next[0][2] = PROD_W'(qa_reg[2]) * PROD_W'(qb_reg[2]);
        prod_next[0][3] = PROD_W'(qa_reg[3]) * PROD_W'(qb_reg[3]);

        prod_next[1][0] = PROD_W'(qa_reg[0]) * PROD_W'(qb_reg[1]);
        prod_next[1][1] = PROD_W'(qa_reg[1]) * PROD_W'(qb_reg[0]);
        prod_next[1][2] = PROD_W'(qa_reg[2]) * PROD_W'(qb_reg[3]);
        prod_next[1][3] = PROD_W'(qa_reg[3]) * PROD_W'(qb_reg[2]);

        prod_next[2][0] = PROD_W'(qa_reg[0]) * PROD_W'(qb_reg[2]);
        prod_next[2][1] = PROD_W'(qa_reg[1]) * PROD_W'(qb_reg[3]);
        prod_next[2][2] = PROD_W'(qa_reg[2]) * PROD_W'(qb_reg[0]);
        prod_next[2][3] = PROD_W'(qa_reg[3]) * PROD_W'(qb_reg[1]);

        prod_next[3][0] = PROD_W'(qa_reg[0]) * PROD_W'(qb_reg[3]);
        prod_next[3][1] = PROD_W'(qa_reg[1]) * PROD_W'(qb_reg[2]);
        prod_next[3][2] = PROD_W'(qa_reg[2]) * PROD_W'(qb_reg[1]);
        prod_next[3][3] = PROD_W'(qa_reg[3]) * PROD_W'(qb_reg[0]);
    end

    always_comb
    begin
        sum_next[0] = SUM_W'(prod_reg[0][0]) - SUM_W'(prod_reg[0][1])
                    - SUM_W'(prod_reg[0][2]) - SUM_W'(prod_reg[0][3]);
        sum_next[1] = SUM_W'(prod_reg[1][0]) + SUM_W'(prod_reg[1][1])
                    + SUM_W'(prod_reg[1][2]) - SUM_W'(prod_reg[1][3]);
        sum_next[2] = SUM_W'(prod_reg[2][0]) - SUM_W'(prod_reg[2][1])
                    + SUM_W'(prod_reg[2][2]) + SUM_W'(prod_reg[2][3]);
        sum_next[3] = SUM_W'(prod_reg[3][0]) + SUM_W'(prod_reg[3][1])
                    - SUM_W'(prod_reg[3][2]) + SUM_W'(prod_reg[3][3]);
    end

    for (genvar c = 0; c < 4; c++)
    begin : g_rsat
        qpm_round_sat u_round_sat (
            .sum (sum_reg[c]),
            .res (rs[c])
        );
    end

    always_ff @(posedge clk)
    begin
        if (en1)
        begin
            qa_reg <= qa_next;
            qb_reg <= qb_next;
        end
        if (en2)
        begin
            prod_reg <= prod_next;
        end
        if (en3)
        begin
            sum_reg <= sum_next;
        end
        if (en4)
        begin
            res_reg[0] <= rs[0].value;
            res_reg[1] <= rs[1].value;
            res_reg[2] <= rs[2].value;
            res_reg[3] <= rs[3].value;
            sat_reg    <= rs[0].clipped | rs[1].clipped | rs[2].clipped | rs[3].clipped;
        end
    end

    assign out_valid = v4_reg;
    assign r_w       = res_reg[0];
    assign r_x       = res_reg[1];
    assign r_y       = res_reg[2];
    assign r_z       = res_reg[3];
    assign saturated = sat_reg;

endmodule
